// ----- hdl/arp_pkg.sv -----
// ----------------------------------------------------------------------------
// Association response parser package
// Phase encoding, status codes, tag bytes and sizing constants shared by the
// parser.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int DEF_MAX_MESSAGE_BYTES = 4096;
  localparam int TITLE_BYTES           = 8;

  localparam logic [7:0] DEF_RESPONSE_TAG = 8'h61;
  localparam logic [7:0] TAG_CONTEXT      = 8'h06;
  localparam logic [7:0] TAG_RESULT       = 8'h02;
  localparam logic [7:0] TAG_DIAG         = 8'hA1;
  localparam logic [7:0] TAG_CTX80        = 8'h80;
  localparam logic [7:0] TAG_USERINFO     = 8'hBE;
  localparam logic [7:0] TAG_INITIATE     = 8'h81;
  localparam logic [7:0] BYTE_ZERO        = 8'h00;
  localparam logic [7:0] BYTE_ONE         = 8'h01;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_PARSE_ERR = 2'd2,
    ST_OVERRUN   = 2'd3
  } status_t;

  // Order matters: the initiate-body phases form one contiguous range.
  typedef enum logic [4:0] {
    PH_TAG, PH_HLEN, PH_CTX, PH_CLEN, PH_RES, PH_RVAL, PH_DIAG, PH_DLEN,
    PH_INV, PH_ILEN, PH_UI, PH_ULEN, PH_UTAG, PH_AUTH, PH_RLEN, PH_CONF,
    PH_VER, PH_VERV, PH_MECH, PH_MECHV, PH_TITLE, PH_TLEN, PH_TBYTES,
    PH_PDU, PH_PDUH, PH_PDUL, PH_REST, PH_DONE
  } phase_t;

endpackage

// ----- hdl/assoc_response_parser.sv -----
// ----------------------------------------------------------------------------
// Association response parser
// Walks a BER-TLV association response one byte per transaction and emits
// one decoded result on the final byte.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// s_*      in         tdata: msg_byte; tlast: is_last
// m_*      out        tuser: status; tdata: decoded fields
// cfg_*    in         response_tag write
//
// One byte is accepted per cycle; the last byte loads the result into the
// output register. The parse step is a single pass of combinational logic on
// the phase register. s_tready drops only while a result waits and m_tready
// is low. Synchronous reset clears the parse state and sets the tag.
// ----------------------------------------------------------------------------
module assoc_response_parser
  import arp_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] msg_byte
  input  logic         s_tlast,   // is_last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // consumed_bytes[12:0], assoc_result[20:13],
                                  // auth_offset[32:21], auth_length[40:33],
                                  // protocol_version[48:41],
                                  // auth_mechanism[56:49], max_pdu_size[72:57],
                                  // sys_title[136:73], title_length[140:137]
  output logic [1:0]   m_tuser,   // status
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata
);

  localparam int PW = $clog2(MAX_MESSAGE_BYTES + 2);
  localparam logic [PW-1:0] POS_SAT = PW'(MAX_MESSAGE_BYTES + 1);

  logic [7:0]    response_tag;
  phase_t        phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [31:0]   acc, acc_next;
  logic [6:0]    lbl, lbl_next;
  logic [7:0]    hdr, hdr_next;
  logic [31:0]   decl, decl_next;
  logic [31:0]   skip, skip_next;
  logic [33:0]   uie, uie_next;
  logic [33:0]   ine, ine_next;
  logic [1:0]    err, err_next;
  logic [7:0]    f_res, f_res_next, f_alen, f_alen_next;
  logic [11:0]   f_aoff, f_aoff_next;
  logic [7:0]    f_ver, f_ver_next, f_mech, f_mech_next;
  logic [15:0]   f_pdu, f_pdu_next;
  logic [63:0]   f_title, f_title_next, tacc, tacc_next;
  logic [3:0]    f_tlen, f_tlen_next;
  logic [7:0]    ttot, ttot_next, tgot, tgot_next;

  logic          s_acc, out_load;
  logic [143:0]  res_data;
  logic [1:0]    res_status;

  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign out_load = s_acc && s_tlast;

  // Length decoder shared by the HLEN, CLEN, DLEN, ULEN and RLEN phases
  logic        tl_done, tl_err;
  logic [6:0]  tl_lbl;
  logic [31:0] tl_acc;
  always_comb begin
    tl_done = 1'b0;
    tl_err  = 1'b0;
    tl_lbl  = lbl;
    tl_acc  = acc;
    if (lbl == 7'd0) begin
      if (!s_tdata[7]) begin
        tl_acc  = 32'(s_tdata);
        tl_done = 1'b1;
      end else if (s_tdata[6:0] == 7'd0) begin
        tl_err = 1'b1;
      end else begin
        tl_lbl = s_tdata[6:0];
        tl_acc = 32'd0;
      end
    end else begin
      tl_acc  = {acc[23:0], s_tdata};
      tl_lbl  = lbl - 7'd1;
      tl_done = (lbl == 7'd1);
    end
  end

  // One parse step for the incoming byte
  logic [7:0]  b;
  logic [33:0] pw, rem, ui_cand;
  logic [31:0] sk;
  phase_t      eph;
  logic [8:0]  tgot_inc;
  always_comb begin
    b = s_tdata;
    pw = 34'(pos);
    phase_next = phase; acc_next = acc; lbl_next = lbl; hdr_next = hdr;
    decl_next = decl; skip_next = skip; uie_next = uie; ine_next = ine;
    err_next = err; f_res_next = f_res; f_aoff_next = f_aoff;
    f_alen_next = f_alen; f_ver_next = f_ver; f_mech_next = f_mech;
    f_pdu_next = f_pdu; f_title_next = f_title; f_tlen_next = f_tlen;
    tacc_next = tacc; ttot_next = ttot; tgot_next = tgot;
    eph = phase;
    sk  = skip;
    ui_cand = pw + 34'd1 + 34'(tl_acc);
    tgot_inc = 9'(tgot) + 9'd1;
    // leave the initiate body once its end is reached
    if (phase inside {[PH_CONF:PH_REST]} && pw >= ine) begin
      sk  = 32'd0;
      eph = PH_UTAG;
      skip_next  = 32'd0;
      phase_next = PH_UTAG;
    end
    rem = (ine > pw) ? ine - pw : 34'd0;
    if (sk != 32'd0) begin
      skip_next = sk - 32'd1;
    end else begin
      // optional elements that are absent fall through to the next one
      if (eph == PH_CTX   && b != TAG_CONTEXT) eph = PH_RES;
      if (eph == PH_RES   && b != TAG_RESULT)  eph = PH_DIAG;
      if (eph == PH_DIAG  && b != TAG_DIAG)    eph = PH_INV;
      if (eph == PH_INV   && b != TAG_CTX80)   eph = PH_UI;
      if (eph == PH_TITLE && b != BYTE_ZERO && b != BYTE_ONE) eph = PH_PDU;
      phase_next = eph;
      case (eph)
        PH_TAG: begin
          if (b != response_tag) begin
            err_next = ST_PARSE_ERR; phase_next = PH_DONE;
          end else phase_next = PH_HLEN;
        end
        PH_HLEN: begin
          lbl_next = tl_lbl; acc_next = tl_acc;
          if (tl_err) begin
            err_next = ST_PARSE_ERR; phase_next = PH_DONE;
          end else if (tl_done) begin
            hdr_next = 8'(pw + 34'd1); decl_next = tl_acc; phase_next = PH_CTX;
          end
        end
        PH_CTX:  phase_next = PH_CLEN;
        PH_CLEN: begin
          lbl_next = tl_lbl; acc_next = tl_acc;
          if (tl_err) begin
            err_next = ST_PARSE_ERR; phase_next = PH_DONE;
          end else if (tl_done) begin
            skip_next = tl_acc; phase_next = PH_RES;
          end
        end
        PH_RES:  phase_next = PH_RVAL;
        PH_RVAL: begin
          f_res_next = b; phase_next = PH_DIAG;
        end
        PH_DIAG: phase_next = PH_DLEN;
        PH_DLEN: begin
          lbl_next = tl_lbl; acc_next = tl_acc;
          if (tl_err) phase_next = PH_ILEN;
          else if (tl_done) begin
            skip_next = tl_acc; phase_next = PH_INV;
          end
        end
        PH_INV:  phase_next = PH_ILEN;
        PH_ILEN: begin
          skip_next = 32'(b); phase_next = PH_UI;
        end
        PH_UI:   phase_next = (b == TAG_USERINFO) ? PH_ULEN : PH_DONE;
        PH_ULEN: begin
          lbl_next = tl_lbl; acc_next = tl_acc;
          if (tl_err) phase_next = PH_DONE;
          else if (tl_done) begin
            uie_next = ui_cand; phase_next = PH_UTAG;
          end
        end
        PH_UTAG: begin
          if (pw >= uie) phase_next = PH_DONE;
          else if (b == TAG_CTX80) phase_next = PH_AUTH;
          else if (b == TAG_INITIATE) begin
            lbl_next = 7'd0; phase_next = PH_RLEN;
          end else phase_next = PH_DONE;
        end
        PH_AUTH: begin
          if (pw >= uie) phase_next = PH_DONE;
          else begin
            f_aoff_next = 12'(pw + 34'd1);
            f_alen_next = b;
            skip_next   = 32'(b);
            phase_next  = PH_UTAG;
          end
        end
        PH_RLEN: begin
          if (pw >= uie) phase_next = PH_DONE;
          else begin
            lbl_next = tl_lbl; acc_next = tl_acc;
            if (tl_err) phase_next = PH_DONE;
            else if (tl_done) begin
              if (ui_cand > uie) phase_next = PH_DONE;
              else begin
                ine_next = ui_cand;
                f_ver_next = 8'd0; f_mech_next = 8'd0; f_pdu_next = 16'd0;
                phase_next = (tl_acc < 32'd3) ? PH_REST : PH_CONF;
              end
            end
          end
        end
        PH_CONF: begin
          if (b == BYTE_ZERO) phase_next = PH_VER;
          else if (b == BYTE_ONE) begin
            skip_next = 32'd4; phase_next = PH_VER;
          end else phase_next = PH_REST;
        end
        PH_VER: begin
          if (rem < 34'd2) phase_next = PH_REST;
          else if (b == BYTE_ZERO) phase_next = PH_MECH;
          else if (b == BYTE_ONE) phase_next = PH_VERV;
          else phase_next = PH_REST;
        end
        PH_VERV: begin
          f_ver_next = b; phase_next = PH_MECH;
        end
        PH_MECH: begin
          if (rem < 34'd2) phase_next = PH_REST;
          else if (b == BYTE_ZERO) phase_next = PH_TITLE;
          else if (b == BYTE_ONE) phase_next = PH_MECHV;
          else phase_next = PH_REST;
        end
        PH_MECHV: begin
          f_mech_next = b; phase_next = PH_TITLE;
        end
        PH_TITLE: phase_next = (b == BYTE_ZERO) ? PH_PDU : PH_TLEN;
        PH_TLEN: begin
          if (34'(b) >= rem) phase_next = PH_REST;
          else begin
            ttot_next = b; tgot_next = 8'd0; tacc_next = 64'd0;
            phase_next = (b == 8'd0) ? PH_PDU : PH_TBYTES;
          end
        end
        PH_TBYTES: begin
          if (tgot < 8'(TITLE_BYTES)) tacc_next = {tacc[55:0], b};
          tgot_next = tgot_inc[7:0];
          if (tgot_inc >= 9'(ttot)) begin
            f_title_next = tacc_next;
            f_tlen_next  = (ttot > 8'(TITLE_BYTES)) ? 4'(TITLE_BYTES) : ttot[3:0];
            phase_next   = PH_PDU;
          end
        end
        PH_PDU:  phase_next = (b == BYTE_ONE && rem >= 34'd3) ? PH_PDUH : PH_REST;
        PH_PDUH: begin
          acc_next = 32'(b); phase_next = PH_PDUL;
        end
        PH_PDUL: begin
          f_pdu_next = {acc[7:0], b}; phase_next = PH_REST;
        end
        default: phase_next = eph;
      endcase
    end
  end

  // Final status from the state after this byte
  logic [32:0] hdr_sum;
  always_comb begin
    pos_next = (pos == POS_SAT) ? pos : pos + PW'(1);
    hdr_sum  = 33'(hdr_next) + 33'(decl_next);
    if (pos_next < PW'(2))                         res_status = ST_SHORT;
    else if (pos_next > PW'(MAX_MESSAGE_BYTES))    res_status = ST_OVERRUN;
    else if (hdr_next == 8'd0)                     res_status = ST_PARSE_ERR;
    else if (hdr_sum > 33'(pos_next))              res_status = ST_OVERRUN;
    else if (err_next != 2'd0)                     res_status = err_next;
    else if (phase_next == PH_CLEN)
      res_status = (lbl_next == 7'd0) ? ST_SHORT : ST_PARSE_ERR;
    else                                           res_status = ST_OK;
    if (res_status == ST_OK)
      res_data = {3'd0, f_tlen_next, f_title_next, f_pdu_next, f_mech_next,
                  f_ver_next, f_alen_next, f_aoff_next, f_res_next, hdr_sum[12:0]};
    else
      res_data = '0;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) response_tag <= DEF_RESPONSE_TAG;
    else if (cfg_we) response_tag <= cfg_wdata;
  end

  // Parse state: advance on each byte, clear after the last one
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      phase <= PH_TAG; pos <= '0; acc <= '0; lbl <= '0; hdr <= '0;
      decl <= '0; skip <= '0; uie <= '0; ine <= '0; err <= '0;
      f_res <= '0; f_aoff <= '0; f_alen <= '0; f_ver <= '0; f_mech <= '0;
      f_pdu <= '0; f_title <= '0; f_tlen <= '0; tacc <= '0; ttot <= '0;
      tgot <= '0;
    end else if (s_acc) begin
      phase <= phase_next; pos <= pos_next; acc <= acc_next; lbl <= lbl_next;
      hdr <= hdr_next; decl <= decl_next; skip <= skip_next; uie <= uie_next;
      ine <= ine_next; err <= err_next; f_res <= f_res_next;
      f_aoff <= f_aoff_next; f_alen <= f_alen_next; f_ver <= f_ver_next;
      f_mech <= f_mech_next; f_pdu <= f_pdu_next; f_title <= f_title_next;
      f_tlen <= f_tlen_next; tacc <= tacc_next; ttot <= ttot_next;
      tgot <= tgot_next;
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_data;
      m_tuser <= res_status;
    end
  end

  // Checks
  a_rise_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result without a final byte");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("error result carries field data");
  a_pos_clear: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (pos == '0 && phase == PH_TAG))
    else $error("parse state not cleared after final byte");
  a_tlen_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[140:137] <= 4'(TITLE_BYTES)))
    else $error("title length beyond limit");

endmodule
